// File: rtl/sha1sh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_pkg: shared types and constants of the SHA-1 stream hasher
// Controller states, command and status bundles, SHA-1 constants.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CINIT,
        ST_ROUND,
        ST_CEND,
        ST_PAD,
        ST_LEN,
        ST_DONE
    } ctrl_state_t;

    // What to do once the current block has been compressed
    typedef enum logic [1:0] {
        RET_MSG,
        RET_PAD,
        RET_FINAL
    } ret_t;

    typedef enum logic [1:0] {
        SRC_MSG,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } round_phase_t;

    typedef struct packed {
        logic         shift_en;
        byte_src_t    byte_src;
        logic [2:0]   len_idx;
        logic         count_byte;
        logic         work_load;
        logic         round_en;
        round_phase_t phase;
        logic         chain_add;
        logic         finish;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

    function automatic logic [31:0] round_k(input round_phase_t ph);
        logic [31:0] k;
        case (ph)
            PH_CH:   k = K0;
            PH_PAR1: k = K1;
            PH_MAJ:  k = K2;
            PH_PAR2: k = K3;
            default: k = K0;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/sha1_stream_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hash: streaming SHA-1 message digest
// Bytes in, big-endian block packing, 80-round compression, standard padding.
// ----------------------------------------------------------------------------
// Throughput: one byte item per cycle while a block fills; each 64th byte then
//   holds tready low for the load, 80 rounds and the chain add.
// After the last item the block pads, appends the bit length, compresses the
//   final block (or two) and, once the output register is free, raises tvalid.
// Reset: rst_n clears control, counters and the chain value (initial constants).
module sha1_stream_hash
(
    input  logic         clk,
    input  logic         rst_n,
    // input item
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] has_byte
    input  logic         s_axis_tlast,   // last
    // result item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // digest_h0 .. digest_h4, 32 bits each
    output logic         m_axis_tuser    // [0] length_overflow
);

    sha1sh_pkg::cmd_t    cmd;
    sha1sh_pkg::status_t status;

    // Sequence intake, padding and compression rounds
    sha1sh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_has   (s_axis_tuser),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the block, run the rounds, keep the chain value and result
    sha1sh_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (s_axis_tdata),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_digest   (m_axis_tdata),
        .out_overflow (m_axis_tuser),
        .status       (status)
    );

endmodule

// File: rtl/sha1sh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_ctrl: SHA-1 stream hasher controller
// Tracks block fill, round count and padding progress; drives the datapath.
// ----------------------------------------------------------------------------
module sha1sh_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_has,
    input  logic               in_last,
    output logic               in_ready,
    input  sha1sh_pkg::status_t status,
    output sha1sh_pkg::cmd_t    cmd
);

    sha1sh_pkg::ctrl_state_t state_reg, state_next;
    sha1sh_pkg::ret_t        ret_reg, ret_next;
    logic [5:0]              fill_reg, fill_next;
    logic [6:0]              round_reg, round_next;
    logic                    mark_reg, mark_next;
    logic                    accept;
    logic                    fill_wrap;

    assign in_ready  = (state_reg == sha1sh_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign fill_wrap = (fill_reg == sha1sh_pkg::FILL_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_has && fill_wrap)
                        state_next = sha1sh_pkg::ST_CINIT;
                    else if (in_last)
                        state_next = sha1sh_pkg::ST_PAD;
                end
            end
            sha1sh_pkg::ST_CINIT:
                state_next = sha1sh_pkg::ST_ROUND;
            sha1sh_pkg::ST_ROUND:
            begin
                if (round_reg == sha1sh_pkg::ROUND_LAST)
                    state_next = sha1sh_pkg::ST_CEND;
            end
            sha1sh_pkg::ST_CEND:
            begin
                case (ret_reg)
                    sha1sh_pkg::RET_MSG:   state_next = sha1sh_pkg::ST_IDLE;
                    sha1sh_pkg::RET_PAD:   state_next = sha1sh_pkg::ST_PAD;
                    sha1sh_pkg::RET_FINAL: state_next = sha1sh_pkg::ST_DONE;
                    default:               state_next = sha1sh_pkg::ST_IDLE;
                endcase
            end
            sha1sh_pkg::ST_PAD:
            begin
                if (fill_wrap)
                    state_next = sha1sh_pkg::ST_CINIT;
                else if (fill_reg + 6'd1 == sha1sh_pkg::FILL_LEN)
                    state_next = sha1sh_pkg::ST_LEN;
            end
            sha1sh_pkg::ST_LEN:
            begin
                if (fill_wrap)
                    state_next = sha1sh_pkg::ST_CINIT;
            end
            sha1sh_pkg::ST_DONE:
            begin
                if (!status.out_full)
                    state_next = sha1sh_pkg::ST_IDLE;
            end
            default:
                state_next = sha1sh_pkg::ST_IDLE;
        endcase
    end

    // counters and flags
    always_comb
    begin
        fill_next  = fill_reg;
        round_next = round_reg;
        ret_next   = ret_reg;
        mark_next  = mark_reg;
        case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                if (accept && in_has)
                begin
                    fill_next = fill_reg + 6'd1;
                    ret_next  = in_last ? sha1sh_pkg::RET_PAD : sha1sh_pkg::RET_MSG;
                end
            end
            sha1sh_pkg::ST_CINIT:
                round_next = '0;
            sha1sh_pkg::ST_ROUND:
                round_next = round_reg + 7'd1;
            sha1sh_pkg::ST_PAD:
            begin
                fill_next = fill_reg + 6'd1;
                mark_next = 1'b1;
                ret_next  = sha1sh_pkg::RET_PAD;
            end
            sha1sh_pkg::ST_LEN:
            begin
                fill_next = fill_reg + 6'd1;
                ret_next  = sha1sh_pkg::RET_FINAL;
            end
            sha1sh_pkg::ST_DONE:
            begin
                if (!status.out_full)
                begin
                    mark_next = 1'b0;
                    fill_next = '0;
                end
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.byte_src   = sha1sh_pkg::SRC_MSG;
        cmd.len_idx    = fill_reg[2:0];
        cmd.phase      = sha1sh_pkg::PH_CH;
        if (round_reg >= 7'd60)
            cmd.phase = sha1sh_pkg::PH_PAR2;
        else if (round_reg >= 7'd40)
            cmd.phase = sha1sh_pkg::PH_MAJ;
        else if (round_reg >= 7'd20)
            cmd.phase = sha1sh_pkg::PH_PAR1;
        case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                cmd.shift_en   = accept && in_has;
                cmd.count_byte = accept && in_has;
            end
            sha1sh_pkg::ST_CINIT:
                cmd.work_load = 1'b1;
            sha1sh_pkg::ST_ROUND:
                cmd.round_en = 1'b1;
            sha1sh_pkg::ST_CEND:
                cmd.chain_add = 1'b1;
            sha1sh_pkg::ST_PAD:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = mark_reg ? sha1sh_pkg::SRC_ZERO : sha1sh_pkg::SRC_MARK;
            end
            sha1sh_pkg::ST_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = sha1sh_pkg::SRC_LEN;
            end
            sha1sh_pkg::ST_DONE:
                cmd.finish = !status.out_full;
            default:
                cmd.shift_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1sh_pkg::ST_IDLE;
            ret_reg   <= sha1sh_pkg::RET_MSG;
            fill_reg  <= '0;
            round_reg <= '0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            mark_reg  <= mark_next;
        end
    end

endmodule

// File: rtl/sha1sh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1sh_datapath: SHA-1 stream hasher datapath
// Block shift register and message schedule, one round unit, chain value,
// byte counter and the output register.
// ----------------------------------------------------------------------------
module sha1sh_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  sha1sh_pkg::cmd_t    cmd,
    input  logic [7:0]          data_byte,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [159:0]        out_digest,
    output logic                out_overflow,
    output sha1sh_pkg::status_t status
);

    logic [511:0] blk_reg, blk_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  h_reg [5];
    logic [31:0]  count_reg;
    logic         ovf_reg;
    logic [159:0] dig_reg;
    logic         dig_ovf_reg;
    logic         valid_reg;

    logic [7:0]   in_byte;
    logic [63:0]  len_bits;
    logic [31:0]  w0, w2, w8, w13, w_mix, w_new;
    logic [31:0]  f_val, t_val;

    assign len_bits = {29'd0, count_reg, 3'd0};

    always_comb
    begin
        case (cmd.byte_src)
            sha1sh_pkg::SRC_MSG:  in_byte = data_byte;
            sha1sh_pkg::SRC_MARK: in_byte = sha1sh_pkg::PAD_MARK;
            sha1sh_pkg::SRC_ZERO: in_byte = 8'd0;
            sha1sh_pkg::SRC_LEN:  in_byte = len_bits[{~cmd.len_idx, 3'b111} -: 8];
            default:              in_byte = 8'd0;
        endcase
    end

    // word i of the block sits at bits [511-32i -: 32]
    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.shift_en)
            blk_next = {blk_reg[503:0], in_byte};
        else if (cmd.round_en)
            blk_next = {blk_reg[479:0], w_new};
    end

    always_comb
    begin
        case (cmd.phase)
            sha1sh_pkg::PH_CH:   f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            sha1sh_pkg::PH_MAJ:  f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            sha1sh_pkg::PH_PAR1,
            sha1sh_pkg::PH_PAR2: f_val = b_reg ^ c_reg ^ d_reg;
            default:             f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w0
                   + sha1sh_pkg::round_k(cmd.phase);

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (cmd.work_load)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.finish)
        begin
            dig_reg     <= {h_reg[4], h_reg[3], h_reg[2], h_reg[1], h_reg[0]};
            dig_ovf_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0]  <= sha1sh_pkg::IV0;
            h_reg[1]  <= sha1sh_pkg::IV1;
            h_reg[2]  <= sha1sh_pkg::IV2;
            h_reg[3]  <= sha1sh_pkg::IV3;
            h_reg[4]  <= sha1sh_pkg::IV4;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.chain_add)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            else if (cmd.finish)
            begin
                h_reg[0] <= sha1sh_pkg::IV0;
                h_reg[1] <= sha1sh_pkg::IV1;
                h_reg[2] <= sha1sh_pkg::IV2;
                h_reg[3] <= sha1sh_pkg::IV3;
                h_reg[4] <= sha1sh_pkg::IV4;
            end

            if (cmd.finish)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.count_byte)
            begin
                if (&count_reg)
                    ovf_reg <= 1'b1;
                else
                    count_reg <= count_reg + 32'd1;
            end

            if (cmd.finish)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    assign out_valid       = valid_reg;
    assign out_digest      = dig_reg;
    assign out_overflow    = dig_ovf_reg;
    assign status.out_full = valid_reg;

endmodule

// File: verif/sha1_stream_hash_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hash_tb: self-checking bench for the streaming SHA-1 hasher
// Feeds byte items framed into messages (empty tails, ignored no-byte items,
// padding boundaries at 55/56/64 bytes), computes each digest in a local
// SHA-1 model and compares every digest item word by word, under random
// backpressure on both sides and one long output stall.
// ----------------------------------------------------------------------------

// Local SHA-1 model plus the queue of digests still owed by the block.
class sha1_digest_tracker;

    localparam bit [31:0] IV0 = 32'h67452301;
    localparam bit [31:0] IV1 = 32'hEFCDAB89;
    localparam bit [31:0] IV2 = 32'h98BADCFE;
    localparam bit [31:0] IV3 = 32'h10325476;
    localparam bit [31:0] IV4 = 32'hC3D2E1F0;
    localparam bit [31:0] RK0 = 32'h5A827999;
    localparam bit [31:0] RK1 = 32'h6ED9EBA1;
    localparam bit [31:0] RK2 = 32'h8F1BBCDC;
    localparam bit [31:0] RK3 = 32'hCA62C1D6;
    localparam bit [5:0]  LEN_POS = 6'd56;
    localparam bit [7:0]  PAD_BYTE = 8'h80;

    bit [31:0]  blk [16];
    bit [31:0]  chain [5];
    bit [31:0]  byte_cnt;
    bit         ovf;
    bit [5:0]   fill;

    bit [159:0] pending_digests [$];
    bit         pending_ovf [$];
    int         errors;

    function new();
        restart();
        errors = 0;
    endfunction

    function void restart();
        chain[0] = IV0;
        chain[1] = IV1;
        chain[2] = IV2;
        chain[3] = IV3;
        chain[4] = IV4;
        byte_cnt = '0;
        ovf      = 1'b0;
        fill     = '0;
    endfunction

    function bit [31:0] rotl(bit [31:0] x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
        bit [31:0] w [16];
        bit [31:0] a, b, c, d, e, f, k, wt, tmp;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int i = 0; i < 16; i++)
            w[i] = blk[i];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                wt = rotl(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^
                          w[(t - 14) & 15] ^ w[t & 15], 1);
                w[t & 15] = wt;
            end
            else
                wt = w[t];
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = RK1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK3;
            end
            tmp = rotl(a, 5) + f + e + wt + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function void put_byte(bit [7:0] v);
        int unsigned sh;
        sh = 24 - 8 * fill[1:0];
        if (fill[1:0] == 2'd0)
            blk[fill[5:2]] = '0;
        blk[fill[5:2]] |= {24'd0, v} << sh;
        fill++;
        if (fill == 6'd0)
            compress();
    endfunction

    // Absorb one accepted input item; a last item queues the digest it causes.
    function void absorb_item(bit [7:0] data, bit has, bit fin);
        bit [63:0] bit_len;
        if (has)
        begin
            if (byte_cnt == 32'hFFFF_FFFF)
                ovf = 1'b1;
            else
                byte_cnt++;
            put_byte(data);
        end
        if (fin)
        begin
            bit_len = {32'd0, byte_cnt} << 3;
            put_byte(PAD_BYTE);
            while (fill != LEN_POS)
                put_byte(8'h00);
            blk[14] = bit_len[63:32];
            blk[15] = bit_len[31:0];
            compress();
            pending_digests.push_back({chain[4], chain[3], chain[2], chain[1], chain[0]});
            pending_ovf.push_back(ovf);
            restart();
        end
    endfunction

    // Compare one accepted digest item with the oldest digest owed.
    function void check_digest(logic [159:0] data, logic user);
        bit [159:0] want_digest;
        bit         want_ovf;
        if (pending_digests.size() == 0)
        begin
            $error("unexpected digest item %h: no message pending", data);
            errors++;
            return;
        end
        want_digest = pending_digests.pop_front();
        want_ovf    = pending_ovf.pop_front();
        for (int j = 0; j < 5; j++)
        begin
            if (data[32*j +: 32] !== want_digest[32*j +: 32])
            begin
                $error("digest_h%0d: expected %08h, actual %08h",
                       j, want_digest[32*j +: 32], data[32*j +: 32]);
                errors++;
            end
        end
        if (user !== want_ovf)
        begin
            $error("length_overflow: expected %0b, actual %0b", want_ovf, user);
            errors++;
        end
    endfunction

endclass

module sha1_stream_hash_tb;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 400;   // > worst padding + two compressions
    localparam int unsigned HOLD_CYCLES  = 3000;  // long output stall
    localparam int unsigned RAND_ITEMS   = 1450;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;    // [7:0] data_byte
    logic         s_axis_tuser;    // [0] has_byte
    logic         s_axis_tlast;    // last
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;    // [31:0] digest_h0 .. [159:128] digest_h4
    logic         m_axis_tuser;    // [0] length_overflow

    sha1_digest_tracker tracker;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;       // items that carry a byte or end a message
    int unsigned cycle_count;
    bit          hold_req;

    // Message lengths around the padding boundaries: one or two final blocks
    int unsigned edge_lens [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    sha1_stream_hash dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: stop a hung run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one item, idling first at the current sender rate, and hold it
    // until the block takes it. Returns right after the accepting edge, so
    // the caller's next drive lands in that same step exactly once.
    task automatic send_item(bit [7:0] data, bit has, bit fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.absorb_item(data, has, fin);
        if (has || fin)
            items_sent++;
    endtask

    // One random message of len bytes; with empty_tail the message is
    // closed by a byte-less last item, otherwise the final byte carries last.
    // Byte-less, non-last items are sprinkled in as noise.
    task automatic send_message(int unsigned len, bit empty_tail);
        bit [7:0] v;
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 6)
                send_item(8'($urandom), 1'b0, 1'b0);
            v = 8'($urandom);
            case ($urandom_range(9))
                0: v = 8'h00;
                1: v = 8'hFF;
                default: ;
            endcase
            send_item(v, 1'b1, !empty_tail && (i == len - 1));
        end
        if (empty_tail)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver: check each accepted digest item, then pick the next tready.
    // Sampling happens on pre-edge values, before any update of this step.
    initial
    begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_digest(m_axis_tdata, m_axis_tuser);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                // Hold off while the sender keeps pushing: the block must
                // park its digest and stall the input side.
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus
    initial
    begin
        int unsigned len;
        bit          tail;
        tracker       = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        hold_req      = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored items, empty message, byte extremes, "abc",
        // and a byte-less last item closing a non-empty message.
        send_idle_pct = 17;
        recv_idle_pct = 73;
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hAA, 1'b0, 1'b1);

        // Random messages in three idling phases; the last one starts with
        // the long output stall.
        while (items_sent < RAND_ITEMS)
        begin
            if (items_sent < RAND_ITEMS / 3)
            begin
                send_idle_pct = 17;
                recv_idle_pct = 73;
            end
            else if (items_sent < 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 17;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req      = 1'b1;
            end
            case ($urandom_range(9))
                0, 1, 2, 3: len = $urandom_range(8);
                4, 5, 6, 7: len = edge_lens[$urandom_range(8)];
                default:    len = $urandom_range(200);
            endcase
            tail = (len == 0) || ($urandom_range(3) == 0);
            send_message(len, tail);
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every owed digest, then let the block settle.
        while (tracker.pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_digests.size() != 0)
        begin
            $error("%0d digest items never arrived", tracker.pending_digests.size());
            tracker.errors++;
        end

        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sha1sh_pkg.sv
rtl/sha1sh_ctrl.sv
rtl/sha1sh_datapath.sv
rtl/sha1_stream_hash.sv
verif/sha1_stream_hash_tb.sv
